[rtl/core/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and initial hash values for the sha-256 engine
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_comp_stat;

    localparam t_state H_INIT = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] LEN_BLK_HI = 3'b111;

    function automatic t_word sha_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word ror(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/core/sha_comp.sv]
// ----------------------------------------------------------------------------
// sha_comp
// iterative sha-256 round unit, one round per cycle
// ----------------------------------------------------------------------------
module sha_comp
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_state     i_chain,
    input  t_word      i_w,
    output t_state     o_v,
    output t_comp_stat o_stat
);

    t_state     r_v;
    t_state     n_v;
    logic [5:0] r_cnt;
    logic       r_busy;
    logic       r_done;

    t_word s0, s1, ch, maj, t1, t2;

    always_comb begin
        s1  = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        s0  = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + s1 + ch + sha_k(r_cnt) + i_w;
        t2  = s0 + maj;
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = t1 + t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_chain;
        end else if (r_busy) begin
            r_v <= n_v;
        end
    end

    assign o_v         = r_v;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[rtl/core/sha256_hash_engine_unit.sv]
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// byte-serial sha-256 hasher with padding and digest word output
// absorb: a beat that fills the block starts a compression in the round unit
// finish: one pad byte per cycle up to the block end, then a compression per block,
// then 8 output beats; the shared round unit does one round per cycle
// input is not ready while a block compresses, pads or the digest is output
// reset: synchronous active-low, chaining words to initial hash values
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_COMP = 4'b0100,
        S_OUT  = 4'b1000
    } t_fsm;

    t_fsm         r_state;
    t_state       r_h;
    logic [511:0] r_blk;
    logic [5:0]   r_fill;
    logic [63:0]  r_len;
    logic         r_fin;
    logic         r_first;
    logic         r_len_blk;
    logic [2:0]   r_ocnt;

    logic         in_beat;
    logic         out_beat;
    logic         shift_byte;
    logic [7:0]   byte_in;
    logic [7:0]   pad_byte;
    logic [63:0]  bits;
    logic [63:0]  len_sh;
    logic         start;
    t_word        w_new;
    t_word        w0, w1, w9, w14;
    t_state       v;
    t_comp_stat   stat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_h[0];
    assign m_axis_tlast  = (r_ocnt == 3'd7);

    assign bits   = {r_len[60:0], 3'b000};
    assign len_sh = bits << {r_fill[2:0], 3'b000};

    always_comb begin
        if (r_first) begin
            pad_byte = PAD_BYTE;
        end else if (r_len_blk && (r_fill[5:3] == LEN_BLK_HI)) begin
            pad_byte = len_sh[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign shift_byte = (in_beat && (s_axis_tuser == OP_ABSORB)) || (r_state == S_PAD);
    assign byte_in    = (r_state == S_PAD) ? pad_byte : s_axis_tdata;
    assign start      = shift_byte && (r_fill == 6'd63);

    // schedule taps
    assign w0  = r_blk[511:480];
    assign w1  = r_blk[479:448];
    assign w9  = r_blk[223:192];
    assign w14 = r_blk[63:32];
    assign w_new = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
                 + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;

    sha_comp u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_chain (r_h),
        .i_w     (w0),
        .o_v     (v),
        .o_stat  (stat)
    );

    always_ff @(posedge i_clk) begin
        if (shift_byte) begin
            r_blk <= {r_blk[503:0], byte_in};
        end else if (stat.busy) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_h       <= H_INIT;
            r_fill    <= '0;
            r_len     <= '0;
            r_fin     <= 1'b0;
            r_first   <= 1'b0;
            r_len_blk <= 1'b0;
            r_ocnt    <= '0;
        end else begin
            if (shift_byte) begin
                r_fill <= r_fill + 6'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (s_axis_tuser == OP_FINISH) begin
                            r_fin   <= 1'b1;
                            r_first <= 1'b1;
                            r_state <= S_PAD;
                        end else begin
                            r_len <= r_len + 64'd1;
                            if (start) begin
                                r_state <= S_COMP;
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    if (r_first) begin
                        r_len_blk <= (r_fill[5:3] != LEN_BLK_HI);
                    end
                    if (start) begin
                        r_state <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (stat.done) begin
                        for (int i = 0; i < 8; i++) begin
                            r_h[i] <= r_h[i] + v[i];
                        end
                        if (!r_fin) begin
                            r_state <= S_IDLE;
                        end else if (r_len_blk) begin
                            r_ocnt  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_len_blk <= 1'b1;
                            r_state   <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_beat) begin
                        r_ocnt <= r_ocnt + 3'd1;
                        if (r_ocnt == 3'd7) begin
                            r_h       <= H_INIT;
                            r_len     <= '0;
                            r_fin     <= 1'b0;
                            r_len_blk <= 1'b0;
                            r_state   <= S_IDLE;
                        end else begin
                            for (int i = 0; i < 7; i++) begin
                                r_h[i] <= r_h[i+1];
                            end
                            r_h[7] <= r_h[0];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/sha256_hash_engine_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_checker
// watches both stream channels of the sha-256 engine, keeps its own running
// hash of every accepted message byte, queues the eight digest words due on
// each finish beat and compares them in order against the output beats
// ----------------------------------------------------------------------------
package sha256_tb_pkg;

    typedef enum logic {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } t_sha_op;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_digest_beat;

endpackage

module sha256_hash_engine_checker
    import sha256_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] operation
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,   // [31:0] digest_word
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_msg_count,
    output int          o_word_count
);

    localparam int MAX_REPORTS = 10;

    localparam logic [0:7][31:0] IV = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    logic [31:0]  chain_h [8];
    logic [7:0]   msg_buf [64];
    int           buf_fill;
    logic [63:0]  byte_total;
    t_digest_beat digest_q [$];
    int           fails;
    int           msgs;
    int           words;

    assign o_fail_count = fails;
    assign o_msg_count  = msgs;
    assign o_word_count = words;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic void restart_message();
        int i;
        for (i = 0; i < 8; i++)
            chain_h[i] = IV[i];
        buf_fill   = 0;
        byte_total = '0;
    endfunction

    function automatic void fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
        for (i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        msg_buf[buf_fill] = b;
        buf_fill++;
        byte_total++;
        if (buf_fill == 64) begin
            fold_block();
            buf_fill = 0;
        end
    endfunction

    function automatic void close_message();
        logic [63:0]  bit_len;
        t_digest_beat beat;
        int i;
        bit_len = byte_total << 3;
        msg_buf[buf_fill] = 8'h80;
        buf_fill++;
        // length field no longer fits, so an extra block goes first
        if (buf_fill > 56) begin
            while (buf_fill < 64) begin
                msg_buf[buf_fill] = 8'h00;
                buf_fill++;
            end
            fold_block();
            buf_fill = 0;
        end
        while (buf_fill < 56) begin
            msg_buf[buf_fill] = 8'h00;
            buf_fill++;
        end
        for (i = 0; i < 8; i++)
            msg_buf[56 + i] = bit_len[63 - 8*i -: 8];
        fold_block();
        for (i = 0; i < 8; i++) begin
            beat.word = chain_h[i];
            beat.last = (i == 7);
            digest_q.push_back(beat);
        end
        msgs++;
        restart_message();
    endfunction

    initial begin
        fails = 0;
        msgs  = 0;
        words = 0;
        restart_message();
    end

    always @(posedge i_clk) begin
        t_digest_beat due;
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (i_s_axis_tuser == OP_FINISH)
                    close_message();
                else
                    take_byte(i_s_axis_tdata);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                words++;
                if (digest_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected output beat word=%08h last=%0b",
                                 $realtime, i_m_axis_tdata, i_m_axis_tlast);
                end else begin
                    due = digest_q.pop_front();
                    if (i_m_axis_tdata !== due.word || i_m_axis_tlast !== due.last) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: exp word=%08h last=%0b got word=%08h last=%0b",
                                     $realtime, due.word, due.last,
                                     i_m_axis_tdata, i_m_axis_tlast);
                    end
                end
            end
        end
        o_pending <= digest_q.size();
    end

endmodule

[tb/sha256_hash_engine_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit_tb
// feeds known short messages and random-length messages around the padding
// and block boundaries through the sha-256 engine, with bursty input and a
// stalling output side; the checker computes and compares every digest
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit_tb;
    import sha256_tb_pkg::*;

    localparam int ITEM_TARGET = 260;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          msg_count;
    int          word_count;
    int          beats_sent = 0;
    int          bytes_sent = 0;
    int          longest_msg = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [9:0]  rx_phase = '0;

    sha256_hash_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha256_hash_engine_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_msg_count     (msg_count),
        .o_word_count    (word_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // output side: always ready, coin flip, long stalls, sparse ready
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 10'd1;
        case (rx_phase[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (rx_phase[4:0] > 5'd20);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d digest words outstanding",
                     idle_cycles, pending);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_beat(input t_sha_op op, input logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        beats_sent++;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    // fill 0: random bytes, 1: all zero, 2: all ones
    task automatic send_message(input int len, input int fill);
        logic [7:0] b;
        int i;
        for (i = 0; i < len; i++) begin
            case (fill)
                1: b = 8'h00;
                2: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_beat(OP_ABSORB, b);
        end
        bytes_sent += len;
        if (len > longest_msg)
            longest_msg = len;
        send_beat(OP_FINISH, 8'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, finish data bits all set
        send_beat(OP_FINISH, 8'hFF);
        send_message(1, 1);
        send_message(1, 2);
        send_beat(OP_ABSORB, 8'h61);
        send_beat(OP_ABSORB, 8'h62);
        send_beat(OP_ABSORB, 8'h63);
        send_beat(OP_FINISH, 8'h00);
        bytes_sent += 3;
        send_message(2, 0);
        wait_drained();

        while (beats_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 11))
                0: len = 55;
                1: len = 56;
                2: len = 63;
                3: len = 64;
                4: len = $urandom_range(110, 130);
                default: len = $urandom_range(0, 24);
            endcase
            // keep the total near the target
            if (beats_sent + len + 1 > ITEM_TARGET)
                len = (ITEM_TARGET - beats_sent > 1) ? ITEM_TARGET - beats_sent - 1 : 0;
            send_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("summary: %0d messages hashed, %0d bytes, longest %0d bytes",
                 msg_count, bytes_sent, longest_msg);
        $display("summary: %0d input beats, %0d digest words compared, %0d mismatches",
                 beats_sent, word_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
